// ===== rtl/core/gle_pkg.sv =====
// Shared types, constants and the gray weights of the Laplacian edge stream.
`default_nettype none
package gle_pkg;

	localparam int PIX_W         = 8;
	localparam int DIM_W         = 13;
	localparam int CNT_W         = 12;
	localparam int CFG_IDX_W     = 2;
	localparam int MAX_DIM       = 4096;
	localparam int MAX_WIDTH_DEF = 4096;
	localparam int RESET_WIDTH   = 640;
	localparam int RESET_HEIGHT  = 480;
	localparam int MIN_DIM       = 3;

	// fixed-point gray weights, scale 2^14
	localparam int GRAY_SUM_W = 22;
	localparam int GRAY_SHIFT = 14;
	localparam logic [GRAY_SUM_W-1:0] GRAY_W0   = 22'd4899;
	localparam logic [GRAY_SUM_W-1:0] GRAY_W1   = 22'd9617;
	localparam logic [GRAY_SUM_W-1:0] GRAY_W2   = 22'd1868;
	localparam logic [GRAY_SUM_W-1:0] GRAY_HALF = 22'd8192;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	typedef struct packed {
		logic [PIX_W-1:0] chan_zero;
		logic [PIX_W-1:0] chan_one;
		logic [PIX_W-1:0] chan_two;
	} in_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] pix_row;
		logic [CNT_W-1:0] pix_col;
		logic [PIX_W-1:0] edge_value;
		logic             frame_done;
	} out_item_t;

	typedef struct packed {
		logic      emit;
		out_item_t item;
	} lap_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/gle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/gle_gray.sv =====
// Fixed-point RGB to gray conversion with rounding.
`default_nettype none
module gle_gray (
	input  wire logic [gle_pkg::PIX_W-1:0] chan_zero,
	input  wire logic [gle_pkg::PIX_W-1:0] chan_one,
	input  wire logic [gle_pkg::PIX_W-1:0] chan_two,
	output logic      [gle_pkg::PIX_W-1:0] gray
);
	import gle_pkg::*;

	logic [GRAY_SUM_W-1:0] sum;

	// max sum is 255*16384 + 8192, fits 22 bits
	assign sum = GRAY_SUM_W'(chan_zero) * GRAY_W0
		+ GRAY_SUM_W'(chan_one) * GRAY_W1
		+ GRAY_SUM_W'(chan_two) * GRAY_W2
		+ GRAY_HALF;

	assign gray = sum[GRAY_SHIFT +: PIX_W];

endmodule
`default_nettype wire

// ===== rtl/core/gle_lap.sv =====
// 4-neighbor Laplacian, absolute value and interior/frame-end flags.
`default_nettype none
module gle_lap (
	input  wire logic [gle_pkg::PIX_W-1:0] mid_pix,
	input  wire logic [gle_pkg::PIX_W-1:0] left_pix,
	input  wire logic [gle_pkg::PIX_W-1:0] right_pix,
	input  wire logic [gle_pkg::PIX_W-1:0] up_pix,
	input  wire logic [gle_pkg::PIX_W-1:0] down_pix,
	input  wire logic [gle_pkg::CNT_W-1:0] row,
	input  wire logic [gle_pkg::CNT_W-1:0] col,
	input  wire logic [gle_pkg::DIM_W-1:0] eff_w,
	input  wire logic [gle_pkg::DIM_W-1:0] eff_h,
	output gle_pkg::lap_res_t              res
);
	import gle_pkg::*;

	localparam int T_W = PIX_W + 3;

	logic [T_W-1:0]   t;
	logic [T_W-1:0]   t_abs;
	logic [DIM_W-1:0] col_p2;
	logic [DIM_W-1:0] row_p1;

	// two's complement, range -1020..1020
	assign t = {1'b0, mid_pix, 2'b00} - T_W'(left_pix) - T_W'(right_pix)
		- T_W'(up_pix) - T_W'(down_pix);
	assign t_abs = t[T_W-1] ? (~t + T_W'(1)) : t;

	assign col_p2 = {1'b0, col} + DIM_W'(2);
	assign row_p1 = {1'b0, row} + DIM_W'(1);

	always_comb begin
		// result belongs to the pixel one row up
		res.emit            = (row >= CNT_W'(2)) && (col >= CNT_W'(1)) && (col_p2 <= eff_w);
		res.item.pix_row    = row - CNT_W'(1);
		res.item.pix_col    = col;
		res.item.edge_value = t_abs[PIX_W-1:0];
		res.item.frame_done = (row_p1 == eff_h) && (col_p2 == eff_w);
	end

endmodule
`default_nettype wire

// ===== rtl/core/gray_laplacian_edge_stream.sv =====
// Top level: streaming gray conversion and 3x3 Laplacian edge detection.
// Throughput: one pixel per clock while the result register is free or being drained; a stalled output holds the input.
// Pipeline: an accepted pixel waits in stage 1 on the registered line-buffer read, then gray and
// kernel logic feed the stage-2 result register, which holds the result for the pixel above it.
// Reset: counters, pipeline valids and window cleared; size registers 640x480 (clamped).
// Line buffers are not cleared; rows 0 and 1 of each frame only prime them.
`default_nettype none
module gray_laplacian_edge_stream #(
	parameter int MAX_WIDTH = gle_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// pixel input
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire gle_pkg::in_item_t                 in_data,
	// result output
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output gle_pkg::out_item_t                     out_data,
	// configuration writes
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [gle_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [gle_pkg::DIM_W-1:0]         cfg_data
);
	import gle_pkg::*;

	// line buffer depth is the widest frame we support
	localparam int DEPTH = (MAX_WIDTH < MAX_DIM) ? MAX_WIDTH : MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [DIM_W-1:0] LIM_W   = DIM_W'(DEPTH);
	localparam logic [DIM_W-1:0] LIM_H   = DIM_W'(MAX_DIM);
	localparam logic [DIM_W-1:0] MIN_D   = DIM_W'(MIN_DIM);
	localparam logic [DIM_W-1:0] RST_W   = (RESET_WIDTH > DEPTH) ? DIM_W'(DEPTH)
		: DIM_W'(RESET_WIDTH);
	localparam logic [DIM_W-1:0] RST_H   = DIM_W'(RESET_HEIGHT);

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] lim);
		logic [DIM_W-1:0] r;
		r = v;
		if (r < MIN_D) begin
			r = MIN_D;
		end
		if (r > lim) begin
			r = lim;
		end
		return r;
	endfunction

	// effective frame size, clamped at write time
	logic [DIM_W-1:0] eff_w_q;
	logic [DIM_W-1:0] eff_h_q;
	// position of the next pixel
	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	// sliding window on the previous row: mid at current column, left one before
	logic [PIX_W-1:0] mid_q;
	logic [PIX_W-1:0] left_q;

	// stage 1: accepted pixel waiting on line-buffer read data
	logic             valid_s1;
	in_item_t         pix_s1;
	logic [CNT_W-1:0] row_s1;
	logic [CNT_W-1:0] col_s1;

	// stage 2: result register
	logic             valid_s2;
	out_item_t        item_s2;

	logic             in_accept;
	logic             cfg_wr;
	logic             cfg_hit;
	logic             s1_adv;
	logic [DIM_W-1:0] col_p1;
	logic [DIM_W-1:0] row_p1;
	logic             row_end;
	logic [CNT_W-1:0] look_col;
	logic [PIX_W-1:0] older_rd;
	logic [PIX_W-1:0] newer_rd;
	logic [PIX_W-1:0] gray_s1;
	lap_res_t         res;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign cfg_hit   = cfg_wr && ((cfg_index == REG_FRAME_WIDTH)
		|| (cfg_index == REG_FRAME_HEIGHT));

	// stage 1 may move on when the result register is free or being drained,
	// or when the pixel produces no result at all
	assign s1_adv    = valid_s1 && (!res.emit || !valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || s1_adv;
	assign in_accept = in_valid && in_ready;

	assign col_p1  = {1'b0, col_q} + DIM_W'(1);
	assign row_p1  = {1'b0, row_q} + DIM_W'(1);
	assign row_end = (col_p1 >= eff_w_q);

	// The previous-row buffer is read one column ahead: that word is this
	// pixel's right neighbor and the next pixel's mid. At the row end it
	// wraps to column 0, which holds the row just finished.
	assign look_col = row_end ? '0 : col_p1[CNT_W-1:0];

	// configuration and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= RST_W;
			eff_h_q <= RST_H;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			if (cfg_hit) begin
				// any size write restarts the frame
				if (cfg_index == REG_FRAME_WIDTH) begin
					eff_w_q <= clamp_dim(cfg_data, LIM_W);
				end else begin
					eff_h_q <= clamp_dim(cfg_data, LIM_H);
				end
				col_q <= '0;
				row_q <= '0;
			end else if (in_accept) begin
				if (row_end) begin
					col_q <= '0;
					row_q <= (row_p1 >= eff_h_q) ? '0 : row_p1[CNT_W-1:0];
				end else begin
					col_q <= col_p1[CNT_W-1:0];
				end
			end
		end
	end

	// line buffers: older holds two rows back, newer one row back
	gle_ram #(
		.WIDTH (PIX_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_line_older (
		.clk     (clk),
		.wr_en   (s1_adv),
		.wr_addr (col_s1[AW-1:0]),
		.wr_data (mid_q),
		.rd_en   (in_accept),
		.rd_addr (col_q[AW-1:0]),
		.rd_data (older_rd)
	);

	gle_ram #(
		.WIDTH (PIX_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_line_newer (
		.clk     (clk),
		.wr_en   (s1_adv),
		.wr_addr (col_s1[AW-1:0]),
		.wr_data (gray_s1),
		.rd_en   (in_accept),
		.rd_addr (look_col[AW-1:0]),
		.rd_data (newer_rd)
	);

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			pix_s1 <= in_data;
			row_s1 <= row_q;
			col_s1 <= col_q;
		end
	end

	// window shifts once per pixel leaving stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q  <= '0;
			left_q <= '0;
		end else if (s1_adv) begin
			left_q <= mid_q;
			mid_q  <= newer_rd;
		end
	end

	gle_gray u_gray (
		.chan_zero (pix_s1.chan_zero),
		.chan_one  (pix_s1.chan_one),
		.chan_two  (pix_s1.chan_two),
		.gray      (gray_s1)
	);

	gle_lap u_lap (
		.mid_pix   (mid_q),
		.left_pix  (left_q),
		.right_pix (newer_rd),
		.up_pix    (older_rd),
		.down_pix  (gray_s1),
		.row       (row_s1),
		.col       (col_s1),
		.eff_w     (eff_w_q),
		.eff_h     (eff_h_q),
		.res       (res)
	);

	// stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv && res.emit) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && res.emit) begin
			item_s2 <= res.item;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = item_s2;

`ifndef ASSERT_OFF
	// results only ever come from interior pixels
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (item_s2.pix_row >= CNT_W'(1)) && (item_s2.pix_col >= CNT_W'(1)))
		else $error("result for a border pixel");

	// position counters stay inside the effective frame
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_q} < eff_w_q)
		else $error("column counter outside frame");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, row_q} < eff_h_q)
		else $error("row counter outside frame");

	// an accepted transaction always lands in stage 1
	a_s1_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> valid_s1)
		else $error("accepted pixel lost before stage 1");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_gray_laplacian_edge_stream.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the gray Laplacian edge stream: directed and random frames against a predictor.
module tb_gray_laplacian_edge_stream;
	import gle_pkg::*;

	// The DUT puts a result in its output register after the pixel below it has passed
	// through stage 1. Wait DRAIN_CYCLES more before touching the size registers.
	localparam int DRAIN_CYCLES  = 8;
	localparam int MAX_GAP       = 12;
	localparam int RANDOM_PIXELS = 400;
	localparam int PRINT_LIMIT   = 60;
	localparam int SHORT_RUN     = 24;
	localparam int TALL_ROWS     = 20;

	// Indexes 2 and 3 decode to no register. A write there must leave the counters alone.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_item_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
	logic [DIM_W-1:0]     cfg_data  = '0;

	// Idle controls. When a flag is set, that side runs with no gaps.
	bit in_burst  = 1'b0;
	bit out_burst = 1'b0;
	int mismatch_count = 0;

	// Predictor state. It mirrors the size registers, the two gray line buffers,
	// the left-neighbour register and the raster position of the next pixel.
	logic [DIM_W-1:0] geo_width  = DIM_W'(RESET_WIDTH);
	logic [DIM_W-1:0] geo_height = DIM_W'(RESET_HEIGHT);
	logic [PIX_W-1:0] gray_two_up [MAX_DIM];
	logic [PIX_W-1:0] gray_one_up [MAX_DIM];
	logic [PIX_W-1:0] gray_left = '0;
	int unsigned      cur_row   = 0;
	int unsigned      cur_col   = 0;

	// Expected edge results, oldest first.
	out_item_t pending_edges [$];

	gray_laplacian_edge_stream #(
		.MAX_WIDTH(MAX_WIDTH_DEF)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Fixed-point luma: weights 0.299/0.587/0.114 at scale 2^14, rounded.
	function automatic logic [PIX_W-1:0] gray_level(input in_item_t px);
		logic [31:0] acc;
		acc = 32'd4899 * px.chan_zero + 32'd9617 * px.chan_one
		    + 32'd1868 * px.chan_two + 32'd8192;
		return acc[21:14];
	endfunction

	// Advance the predictor by one accepted pixel. If the pixel completes the
	// neighbourhood of the interior pixel above it, queue that pixel's result.
	task automatic predict_edge(input in_item_t px);
		int unsigned      wd, ht, r, c;
		logic [PIX_W-1:0] g, up, mid, right;
		int               lap;
		out_item_t        want;
		// Sizes are clamped to [3, 4096]. The line buffers also cap the width.
		wd = (geo_width < MIN_DIM) ? MIN_DIM : geo_width;
		if (wd > MAX_WIDTH_DEF) wd = MAX_WIDTH_DEF;
		if (wd > MAX_DIM) wd = MAX_DIM;
		ht = (geo_height < MIN_DIM) ? MIN_DIM : geo_height;
		if (ht > MAX_DIM) ht = MAX_DIM;
		r = cur_row;
		c = cur_col;
		if (c >= wd) c = 0;
		if (r >= ht) r = 0;

		g     = gray_level(px);
		up    = gray_two_up[c];
		mid   = gray_one_up[c];
		right = (c + 1 < wd) ? gray_one_up[c + 1] : '0;

		// The center is one row up. Border rows and columns give no result.
		if (r >= 2 && c >= 1 && c + 2 <= wd) begin
			lap = 4 * int'(mid) - int'(gray_left) - int'(right) - int'(up) - int'(g);
			if (lap < 0) lap = -lap;
			want.pix_row    = CNT_W'(r - 1);
			want.pix_col    = CNT_W'(c);
			want.edge_value = lap[PIX_W-1:0];
			want.frame_done = (r + 1 == ht) && (c + 2 == wd);
			pending_edges.push_back(want);
		end

		gray_left      = mid;
		gray_two_up[c] = mid;
		gray_one_up[c] = g;

		if (c + 1 >= wd) begin
			cur_col = 0;
			cur_row = (r + 1 >= ht) ? 0 : r + 1;
		end else begin
			cur_col = c + 1;
			cur_row = r;
		end
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_LIMIT)
			$display("%0t ns  mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_edge(input out_item_t got);
		out_item_t want;
		if (pending_edges.size() == 0) begin
			report_mismatch($sformatf("unexpected result row %0d col %0d value %0d",
				got.pix_row, got.pix_col, got.edge_value));
		end else begin
			want = pending_edges.pop_front();
			if (got.pix_row !== want.pix_row)
				report_mismatch($sformatf("pix_row got %0d want %0d (col %0d)",
					got.pix_row, want.pix_row, want.pix_col));
			if (got.pix_col !== want.pix_col)
				report_mismatch($sformatf("pix_col got %0d want %0d (row %0d)",
					got.pix_col, want.pix_col, want.pix_row));
			if (got.edge_value !== want.edge_value)
				report_mismatch($sformatf("edge_value got %0d want %0d at (%0d,%0d)",
					got.edge_value, want.edge_value, want.pix_row, want.pix_col));
			if (got.frame_done !== want.frame_done)
				report_mismatch($sformatf("frame_done got %b want %b at (%0d,%0d)",
					got.frame_done, want.frame_done, want.pix_row, want.pix_col));
		end
	endtask

	// Each output transaction is taken at the edge where valid and ready are both high.
	// The values read here are the ones from before the edge.
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_ready === 1'b1)
			check_edge(out_data);
	end

	// Result sink. Before each transaction it may draw a random stall with ready low,
	// or none in burst stretches. Ready stays high across transactions with no stall drawn.
	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = out_burst ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// Send one pixel transaction. Valid is lowered only when a gap follows, so a
	// back-to-back pixel just replaces the payload at the acceptance edge.
	task automatic send_pixel(input in_item_t px);
		int gap;
		gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= px;
		do @(posedge clk); while (in_ready !== 1'b1);
		predict_edge(px);
	endtask

	// Size writes happen only while idle. Wait for every queued result, then let
	// the pipeline settle. A pixel on a border can still be in flight with nothing queued.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		in_valid <= 1'b0;
		while (pending_edges.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		// Any size write restarts the frame. Spare indexes change nothing.
		if (idx == REG_FRAME_WIDTH) begin
			geo_width = val;
			cur_row   = 0;
			cur_col   = 0;
		end else if (idx == REG_FRAME_HEIGHT) begin
			geo_height = val;
			cur_row    = 0;
			cur_col    = 0;
		end
	endtask

	// Channels hit 0 and 255 often, which pushes the Laplacian past 8 bits.
	function automatic logic [PIX_W-1:0] random_channel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	function automatic in_item_t random_pixel();
		in_item_t px;
		px.chan_zero = random_channel();
		px.chan_one  = random_channel();
		px.chan_two  = random_channel();
		return px;
	endfunction

	// Long runs redraw the idle and burst flags every 256 pixels, so gapped and burst stretches mix.
	task automatic send_random_pixels(input int count);
		int i;
		for (i = 0; i < count; i++) begin
			if (i % 256 == 0) begin
				in_burst  = ($urandom_range(0, 2) == 0);
				out_burst = ($urandom_range(0, 2) == 0);
			end
			send_pixel(random_pixel());
		end
	endtask

	// 3x3 frame with a flat ring around one center. Equal channels give gray == value.
	task automatic send_cross(input logic [PIX_W-1:0] center, input logic [PIX_W-1:0] ring);
		int i;
		logic [PIX_W-1:0] v;
		for (i = 0; i < 9; i++) begin
			v = (i == 4) ? center : ring;
			send_pixel('{chan_zero: v, chan_one: v, chan_two: v});
		end
	endtask

	// Mostly small sizes. Sometimes one below the minimum, sometimes a wider one.
	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(0, 9))
			0: return DIM_W'($urandom_range(0, MIN_DIM - 1));
			1: return DIM_W'($urandom_range(13, 40));
			default: return DIM_W'($urandom_range(MIN_DIM, 12));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// After reset the sizes are 640x480. A short run inside row 0 must give no result.
	task automatic test_reset_size();
		send_random_pixels(SHORT_RUN);
	endtask

	// Smallest frame, one interior pixel. Covers the largest positive and negative
	// responses, both truncated to 8 bits, and each channel alone at full scale.
	task automatic test_kernel_extremes();
		int i;
		in_item_t px;
		write_reg(REG_FRAME_WIDTH, DIM_W'(MIN_DIM));
		write_reg(REG_FRAME_HEIGHT, DIM_W'(MIN_DIM));
		send_cross('1, '0);
		send_cross('0, '1);
		for (i = 0; i < 9; i++) begin
			px = '0;
			case (i % 4)
				0: px.chan_zero = '1;
				1: px.chan_one  = '1;
				2: px.chan_two  = '1;
				default: px = '1;
			endcase
			send_pixel(px);
		end
	endtask

	// Sizes below the minimum clamp to 3. Each setting gets one full frame.
	task automatic test_size_clamp_low();
		write_reg(REG_FRAME_WIDTH, DIM_W'(0));
		write_reg(REG_FRAME_HEIGHT, DIM_W'(0));
		send_random_pixels(9);
		write_reg(REG_FRAME_WIDTH, DIM_W'(2));
		write_reg(REG_FRAME_HEIGHT, DIM_W'(1));
		send_random_pixels(9);
		write_reg(REG_FRAME_HEIGHT, DIM_W'(2));
		write_reg(REG_FRAME_WIDTH, DIM_W'(1));
		send_random_pixels(9);
	endtask

	// Writes during a frame. Spare indexes must not restart it. A size write must.
	task automatic test_midframe_write();
		write_reg(REG_FRAME_WIDTH, DIM_W'(6));
		write_reg(REG_FRAME_HEIGHT, DIM_W'(4));
		send_random_pixels(8);
		write_reg(REG_SPARE_A, '0);
		send_random_pixels(7);
		write_reg(REG_SPARE_B, '1);
		send_random_pixels(4);
		write_reg(REG_FRAME_HEIGHT, DIM_W'(4));
		send_random_pixels(6 * 4 + 13);
		write_reg(REG_FRAME_WIDTH, DIM_W'(5));
		send_random_pixels(2 * 5 * 4);
	endtask

	// Width register at its top code clamps to 4096. A short run stays in row 0
	// and must give no result.
	task automatic test_wide_frame();
		write_reg(REG_FRAME_WIDTH, '1);
		write_reg(REG_FRAME_HEIGHT, DIM_W'(MIN_DIM));
		send_random_pixels(SHORT_RUN);
	endtask

	// Height register at its top code clamps to 4096. A narrow frame gives results
	// row after row with no frame end in sight.
	task automatic test_tall_frame();
		write_reg(REG_FRAME_WIDTH, DIM_W'(MIN_DIM));
		write_reg(REG_FRAME_HEIGHT, '1);
		send_random_pixels(MIN_DIM * TALL_ROWS);
	endtask

	// Random sizes with whole frames back to back, so the counters wrap at frame end.
	// Some runs cut the last frame short; the next size write restarts it. The
	// total is capped, so the very last frame may also end early.
	task automatic test_random_frames();
		int sent, wd, ht, frames, f, n;
		logic [DIM_W-1:0] wsel, hsel;
		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			wsel = pick_dim();
			hsel = pick_dim();
			if ($urandom_range(0, 1)) begin
				write_reg(REG_FRAME_WIDTH, wsel);
				write_reg(REG_FRAME_HEIGHT, hsel);
			end else begin
				write_reg(REG_FRAME_HEIGHT, hsel);
				write_reg(REG_FRAME_WIDTH, wsel);
			end
			if ($urandom_range(0, 5) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, DIM_W'($urandom));
			wd = (wsel < MIN_DIM) ? MIN_DIM : wsel;
			ht = (hsel < MIN_DIM) ? MIN_DIM : hsel;
			frames = $urandom_range(1, 3);
			for (f = 0; f < frames; f++) begin
				n = wd * ht;
				if (f == frames - 1 && $urandom_range(0, 5) == 0)
					n = $urandom_range(1, n - 1);
				if (n > RANDOM_PIXELS - sent)
					n = RANDOM_PIXELS - sent;
				send_random_pixels(n);
				sent += n;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_size();
		test_kernel_extremes();
		test_size_clamp_low();
		test_midframe_write();
		test_wide_frame();
		test_tall_frame();
		test_random_frames();

		// Drain: every queued result must come out, then look for stray results.
		in_valid <= 1'b0;
		while (pending_edges.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog. It allows several times the slowest correct run: about 660 pixels,
	// each with a full input gap and a full output stall, plus the register writes.
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
